// ===== hdl/lbs_pkg.sv =====
// Shared types and constants for the linear blend skinning block.
`timescale 1ns / 1ps
package lbs_pkg;

  localparam int MaxLanes  = 4;   // index and weight fields carried by one request
  localparam int IdxBits   = 6;
  localparam int NumElem   = 12;  // matrix elements that reach x, y, z (columns 0..2)
  localparam int ProdBits  = 49;  // palette value times Q1.16 weight
  localparam int BlendBits = 35;  // sum of four products, shifted right by 16
  localparam int XBits     = 48;  // low bits of a coordinate product that matter

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_SKIN  = 1'b1;

  typedef logic signed [ProdBits-1:0]  prod_t;
  typedef logic signed [BlendBits-1:0] blend_t;
  typedef logic signed [31:0]          q16_t;
  typedef prod_t  prod_row_t [NumElem];
  typedef blend_t blend_row_t [NumElem];

  typedef struct packed {
    logic               we;
    logic [IdxBits-1:0] bone;
    logic [3:0]         elem;
    logic [31:0]        value;
  } pal_wr_t;

endpackage

// ===== hdl/lbs_if.sv =====
// Request and result channel interfaces.
`timescale 1ns / 1ps
interface lbs_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [23:0] bone_indices;
  logic [16:0] weight_0;
  logic [16:0] weight_1;
  logic [16:0] weight_2;
  logic [16:0] weight_3;
  logic [5:0]  palette_bone;
  logic [3:0]  palette_element;
  logic signed [31:0] palette_value;

  modport source (output valid, operation, pos_x, pos_y, pos_z, bone_indices, weight_0,
                  weight_1, weight_2, weight_3, palette_bone, palette_element,
                  palette_value, input ready);
  modport sink (input valid, operation, pos_x, pos_y, pos_z, bone_indices, weight_0,
                weight_1, weight_2, weight_3, palette_bone, palette_element,
                palette_value, output ready);
endinterface

interface lbs_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;

  modport source (output valid, out_x, out_y, out_z, input ready);
  modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface

// ===== hdl/linear_blend_skinning.sv =====
// A skin request passes the palette read, product, merge, transform and result registers.
// Throughput: one request per cycle while the result is not stalled; each influence lane
// reads its bone's twelve matrix elements from its own palette banks in parallel.
// A stalled result stalls the whole pipeline.
// Reset clears the pipeline valid bits; palette contents are undefined until written.
// Palette writes produce no result.
`timescale 1ns / 1ps
module linear_blend_skinning import lbs_pkg::*; #(
  parameter int NUM_BONES  = 64,
  parameter int INFLUENCES = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  lbs_in_if.sink    in_ch,
  lbs_out_if.source out_ch
);
  localparam int LANES = INFLUENCES < MaxLanes ? INFLUENCES : MaxLanes;

  logic       en, acc_in, skin;
  logic [3:0] v_r, v_nxt;
  logic       out_valid_r;
  pal_wr_t    wr;
  q16_t       pos0 [3];
  q16_t       pos1_r [3], pos2_r [3], pos3_r [3];
  q16_t       res_r [3];
  prod_row_t  prod [LANES];
  blend_row_t blend_r;
  logic [16:0] weights [MaxLanes];

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;
  assign acc_in      = in_ch.valid && en;
  assign skin        = acc_in && (in_ch.operation == OP_SKIN);

  assign wr.we    = acc_in && (in_ch.operation == OP_WRITE);
  assign wr.bone  = in_ch.palette_bone;
  assign wr.elem  = in_ch.palette_element;
  assign wr.value = in_ch.palette_value;

  assign weights[0] = in_ch.weight_0;
  assign weights[1] = in_ch.weight_1;
  assign weights[2] = in_ch.weight_2;
  assign weights[3] = in_ch.weight_3;

  assign pos0[0] = in_ch.pos_x;
  assign pos0[1] = in_ch.pos_y;
  assign pos0[2] = in_ch.pos_z;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    lbs_lane #(.NUM_BONES(NUM_BONES)) u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .wr    (wr),
      .rd    (skin),
      .bone  (in_ch.bone_indices[IdxBits*l +: IdxBits]),
      .weight(weights[l]),
      .prod_r(prod[l])
    );
  end

  lbs_merge #(.LANES(LANES)) u_merge (
    .clk    (clk),
    .en     (en),
    .prod   (prod),
    .blend_r(blend_r)
  );

  lbs_xform u_xform (
    .clk  (clk),
    .en   (en),
    .blend(blend_r),
    .pos  (pos3_r),
    .res_r(res_r)
  );

  assign v_nxt = {v_r[2:0], skin};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= v_nxt;
      out_valid_r <= v_r[3];
    end
  end

  // position rides alongside the palette read, product and merge stages
  always_ff @(posedge clk) begin
    if (en) begin
      pos1_r <= pos0;
      pos2_r <= pos1_r;
      pos3_r <= pos2_r;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.out_x = res_r[0];
  assign out_ch.out_y = res_r[1];
  assign out_ch.out_z = res_r[2];

`ifndef SYNTH
  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("request accepted while result stalled");

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    wr.we |=> !v_r[0])
    else $error("palette write entered the result pipeline");

  a_skin_tracked: assert property (@(posedge clk) disable iff (!rst_n)
    skin |=> v_r[0])
    else $error("skin request lost at pipeline entry");
`endif
endmodule

// ===== hdl/lbs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== hdl/lbs_lane.sv =====
// One influence lane: banked palette copy, weight stage and weighted products.
`timescale 1ns / 1ps
module lbs_lane import lbs_pkg::*; #(
  parameter int NUM_BONES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  pal_wr_t            wr,
  input  logic               rd,
  input  logic [IdxBits-1:0] bone,
  input  logic [16:0]        weight,
  output prod_row_t          prod_r
);
  localparam int AW = NUM_BONES > 1 ? $clog2(NUM_BONES) : 1;

  logic        wr_ok;
  logic        hit_r, hit_nxt;
  logic [16:0] weight_r;
  logic [31:0] rdata [NumElem];

  assign wr_ok   = wr.we && (int'(wr.bone) < NUM_BONES);
  assign hit_nxt = rd && (int'(bone) < NUM_BONES);

  for (genvar k = 0; k < NumElem; k++) begin : g_bank
    localparam int Elem = (k / 3) * 4 + (k % 3);
    logic signed [49:0] full;

    lbs_ram #(.WIDTH(32), .DEPTH(NUM_BONES)) u_ram (
      .clk  (clk),
      .we   (wr_ok && (wr.elem == 4'(Elem))),
      .waddr(AW'(wr.bone)),
      .wdata(wr.value),
      .re   (en),
      .raddr(AW'(bone)),
      .rdata(rdata[k])
    );

    assign full = $signed(rdata[k]) * $signed({1'b0, weight_r});

    always_ff @(posedge clk) begin
      if (en) begin
        prod_r[k] <= hit_r ? ProdBits'(full) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (en) begin
      hit_r <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      weight_r <= weight;
    end
  end
endmodule

// ===== hdl/lbs_merge.sv =====
// Merge stage: sums the lane products into the blended matrix.
`timescale 1ns / 1ps
module lbs_merge import lbs_pkg::*; #(
  parameter int LANES = 4
) (
  input  logic       clk,
  input  logic       en,
  input  prod_row_t  prod [LANES],
  output blend_row_t blend_r
);
  logic signed [ProdBits+1:0] sum [NumElem];

  always_comb begin
    for (int k = 0; k < NumElem; k++) begin
      sum[k] = '0;
      for (int l = 0; l < LANES; l++) begin
        sum[k] = sum[k] + (ProdBits+2)'(prod[l][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NumElem; k++) begin
        blend_r[k] <= BlendBits'(sum[k] >>> 16);
      end
    end
  end
endmodule

// ===== hdl/lbs_xform.sv =====
// Row-vector transform of the position by the blended matrix.
`timescale 1ns / 1ps
module lbs_xform import lbs_pkg::*; (
  input  logic       clk,
  input  logic       en,
  input  blend_row_t blend,
  input  q16_t       pos [3],
  output q16_t       res_r [3]
);
  logic signed [XBits-1:0] px_r [3][3];
  logic [31:0]             trans_r [3];
  logic signed [66:0]      full [3][3];
  logic [XBits-1:0]        acc [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        full[c][r] = pos[r] * blend[r * 3 + c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          px_r[c][r] <= XBits'(full[c][r]);
        end
        trans_r[c] <= blend[9 + c][31:0];
      end
    end
  end

  // translation row enters at weight 65536; only bits 16..47 survive
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc[c] = px_r[c][0] + px_r[c][1] + px_r[c][2] + {trans_r[c], 16'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        res_r[c] <= acc[c][47:16];
      end
    end
  end
endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the four-influence linear blend skinning block.
`timescale 1ns / 1ps
module testbench;
  import lbs_pkg::*;

  localparam int NumBones  = 64;
  localparam int StallMax  = 2000;
  localparam int LongHold  = 300;

  typedef struct {
    logic        op;
    q16_t        px, py, pz;
    logic [23:0] idx;
    logic [16:0] w [4];
    logic [5:0]  bone;
    logic [3:0]  elem;
    q16_t        value;
  } lbs_req_t;

  typedef struct {
    q16_t x, y, z;
  } vertex_t;

  logic clk;
  logic rst_n;

  lbs_in_if  in_ch ();
  lbs_out_if out_ch ();

  linear_blend_skinning dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  q16_t    pal_shadow [NumBones*16];
  vertex_t vertex_q [$];
  int      mismatches;
  int      skins_checked;
  int      writes_sent;
  int      burst_left;
  int      idle_cycles;
  int      hold_req;
  int      rx_mode;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Blend the named bone matrices, then transform (x,y,z,1).
  function automatic vertex_t skin_vertex(lbs_req_t r);
    longint  blend [16];
    longint  acc;
    logic [63:0] sum;
    logic [5:0]  b;
    vertex_t v;
    q16_t    res [3];
    for (int e = 0; e < 16; e++) begin
      acc = 0;
      for (int i = 0; i < 4; i++) begin
        b = r.idx[6*i +: 6];
        acc += longint'(pal_shadow[b*16 + e]) * longint'({47'd0, r.w[i]});
      end
      blend[e] = acc >>> 16;
    end
    for (int c = 0; c < 3; c++) begin
      sum = 64'(longint'(r.px) * blend[c]) + 64'(longint'(r.py) * blend[4 + c])
          + 64'(longint'(r.pz) * blend[8 + c]) + (64'(blend[12 + c]) << 16);
      res[c] = sum[47:16];
    end
    v.x = res[0];
    v.y = res[1];
    v.z = res[2];
    return v;
  endfunction

  function automatic q16_t pick_q16();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sh0001_0000;
      3: return 32'sh0000_0000;
      4, 5: return q16_t'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
      default: return q16_t'($urandom);
    endcase
  endfunction

  function automatic logic [16:0] pick_weight();
    case ($urandom_range(0, 5))
      0: return 17'd65536;
      1: return 17'd0;
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic lbs_req_t blank_req();
    lbs_req_t r;
    r.op = OP_SKIN;
    r.px = '0; r.py = '0; r.pz = '0;
    r.idx = '0;
    for (int i = 0; i < 4; i++) r.w[i] = '0;
    r.bone = '0; r.elem = '0; r.value = '0;
    return r;
  endfunction

  function automatic lbs_req_t write_req(logic [5:0] bone, logic [3:0] elem, q16_t value);
    lbs_req_t r;
    r = blank_req();
    r.op = OP_WRITE;
    r.bone = bone;
    r.elem = elem;
    r.value = value;
    return r;
  endfunction

  function automatic lbs_req_t rand_skin();
    lbs_req_t r;
    r = blank_req();
    r.px = pick_q16();
    r.py = pick_q16();
    r.pz = pick_q16();
    r.idx = 24'($urandom);
    for (int i = 0; i < 4; i++) r.w[i] = pick_weight();
    return r;
  endfunction

  // Drive one request at the falling edge and hold it until accepted.
  task automatic send_req(lbs_req_t r);
    if (burst_left == 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat ($urandom_range(0, 1) ? $urandom_range(1, 6) : 0) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid           = 1'b1;
    in_ch.operation       = r.op;
    in_ch.pos_x           = r.px;
    in_ch.pos_y           = r.py;
    in_ch.pos_z           = r.pz;
    in_ch.bone_indices    = r.idx;
    in_ch.weight_0        = r.w[0];
    in_ch.weight_1        = r.w[1];
    in_ch.weight_2        = r.w[2];
    in_ch.weight_3        = r.w[3];
    in_ch.palette_bone    = r.bone;
    in_ch.palette_element = r.elem;
    in_ch.palette_value   = r.value;
    do @(posedge clk); while (!in_ch.ready);
    if (r.op == OP_WRITE) begin
      pal_shadow[r.bone*16 + r.elem] = r.value;
      writes_sent++;
    end else begin
      vertex_q.push_back(skin_vertex(r));
    end
  endtask

  task automatic go_idle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    burst_left = 0;
  endtask

  task automatic wait_drained();
    go_idle();
    while (vertex_q.size() != 0) @(negedge clk);
  endtask

  // Every entry gets a value before any skin request reads it.
  task automatic test_fill_palette();
    for (int b = 0; b < NumBones; b++)
      for (int e = 0; e < 16; e++)
        send_req(write_req(6'(b), 4'(e), pick_q16()));
  endtask

  task automatic test_directed();
    lbs_req_t r;
    // identity on bone 0, extremes on bone 63
    for (int e = 0; e < 16; e++)
      send_req(write_req(6'd0, 4'(e), (e % 5 == 0) ? 32'sh0001_0000 : 32'sh0));
    send_req(write_req(6'd63, 4'd0, 32'sh8000_0000));
    send_req(write_req(6'd63, 4'd5, 32'sh7fff_ffff));
    r = blank_req();
    r.px = 32'sh7fff_ffff; r.py = 32'sh8000_0000; r.pz = 32'sh0001_8000;
    r.w[0] = 17'd65536;
    send_req(r);
    r.idx = {6'd63, 6'd63, 6'd63, 6'd63};
    for (int i = 0; i < 4; i++) r.w[i] = 17'd65536;
    send_req(r);
    r.px = 32'sh8000_0000; r.py = 32'sh7fff_ffff; r.pz = 32'sh8000_0000;
    send_req(r);
    for (int i = 0; i < 4; i++) r.w[i] = 17'd0;
    send_req(r);
    // weights that do not sum to one
    r.idx = {6'd0, 6'd63, 6'd0, 6'd63};
    r.w[0] = 17'd40000; r.w[1] = 17'd1; r.w[2] = 17'd65535; r.w[3] = 17'd30000;
    send_req(r);
    wait_drained();
  endtask

  task automatic test_random(int count);
    lbs_req_t r;
    for (int n = 0; n < count; n++) begin
      if (n == count / 3) hold_req = 1;
      if (n == 2 * count / 3) wait_drained();
      if (n % 150 == 0) rx_mode = $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0)
        r = write_req(6'($urandom), 4'($urandom), pick_q16());
      else
        r = rand_skin();
      send_req(r);
    end
    go_idle();
  endtask

  // Result side: stall pattern, long hold on request, and the checker.
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_req = 0;
      idle_cycles = LongHold;
    end
    if (idle_cycles > 0) begin
      idle_cycles--;
      out_ch.ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        default: out_ch.ready <= ($urandom_range(0, 1) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    vertex_t exp_v;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (vertex_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result x=%0d y=%0d z=%0d",
                                       out_ch.out_x, out_ch.out_y, out_ch.out_z);
      end else begin
        exp_v = vertex_q.pop_front();
        skins_checked++;
        if (out_ch.out_x !== exp_v.x || out_ch.out_y !== exp_v.y ||
            out_ch.out_z !== exp_v.z) begin
          mismatches++;
          if (mismatches <= 10)
            $display("vertex mismatch: expected (%0d,%0d,%0d) got (%0d,%0d,%0d)",
                     exp_v.x, exp_v.y, exp_v.z, out_ch.out_x, out_ch.out_y, out_ch.out_z);
        end
      end
    end
  end

  // Abort when nothing moves for too long.
  int stuck;
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (!in_ch.valid && vertex_q.size() == 0))
      stuck <= 0;
    else
      stuck <= stuck + 1;
    if (stuck >= StallMax) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    mismatches = 0; skins_checked = 0; writes_sent = 0;
    burst_left = 0; idle_cycles = 0; hold_req = 0; rx_mode = 0; stuck = 0;
    out_ch.ready = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_WRITE;
    in_ch.pos_x = '0; in_ch.pos_y = '0; in_ch.pos_z = '0;
    in_ch.bone_indices = '0;
    in_ch.weight_0 = '0; in_ch.weight_1 = '0; in_ch.weight_2 = '0; in_ch.weight_3 = '0;
    in_ch.palette_bone = '0; in_ch.palette_element = '0; in_ch.palette_value = '0;
    rst_n = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    test_fill_palette();
    test_directed();
    test_random(700);

    while (vertex_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("Covered %0d palette writes and %0d checked vertices,", writes_sent,
             skins_checked);
    $display("with bursty input, random output stalls and one long output hold.");
    if (mismatches == 0 && vertex_q.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
